@@ hdl/b64e_pkg.sv @@
// b64e_pkg: shared types, constants and the alphabet function of the base64 encoder
// no dependencies; compiled first
package b64e_pkg;

  // one complete group as it travels from front to back
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;   // real bytes in the group, 1 to 3
    logic       last;     // group ends the message
  } group_t;

  // position of a character inside its group
  typedef logic [1:0] char_idx_t;

  localparam char_idx_t IDX_FIRST  = 2'd0;
  localparam char_idx_t IDX_SECOND = 2'd1;
  localparam char_idx_t IDX_THIRD  = 2'd2;
  localparam char_idx_t IDX_FOURTH = 2'd3;

  // held byte counts
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  // group sizes
  localparam logic [1:0] GROUP_TWO   = 2'd2;
  localparam logic [1:0] GROUP_THREE = 2'd3;

  // ascii codes
  localparam logic [6:0] PAD_CHAR     = 7'd61;  // '='
  localparam logic [6:0] CHAR_UPPER_A = 7'd65;  // 'A'
  localparam logic [6:0] CHAR_LOWER_A = 7'd97;  // 'a'
  localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;  // '0'
  localparam logic [6:0] CHAR_PLUS    = 7'd43;  // '+'
  localparam logic [6:0] CHAR_SLASH   = 7'd47;  // '/'

  // alphabet ranges
  localparam logic [5:0] SEXTET_LOWER = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT = 6'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  // standard alphabet lookup for one six-bit value
  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [6:0] sx;
    logic [6:0] res;
    sx = {1'b0, s};
    if (s < SEXTET_LOWER) begin
      res = CHAR_UPPER_A + sx;
    end else if (s < SEXTET_DIGIT) begin
      res = CHAR_LOWER_A + sx - {1'b0, SEXTET_LOWER};
    end else if (s < SEXTET_PLUS) begin
      res = CHAR_DIGIT_0 + sx - {1'b0, SEXTET_DIGIT};
    end else if (s == SEXTET_PLUS) begin
      res = CHAR_PLUS;
    end else begin
      res = CHAR_SLASH;
    end
    return res;
  endfunction

endpackage

@@ hdl/b64e_in_if.sv @@
// b64e_in_if: byte channel of the base64 encoder
// depends on nothing; valid/ready handshake with byte payload
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/b64e_out_if.sv @@
// b64e_out_if: character channel of the base64 encoder
// depends on nothing; valid/ready handshake with character payload
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_text;

  modport source (output valid, output out_char, output end_of_text, input ready);
  modport sink   (input valid, input out_char, input end_of_text, output ready);
endinterface

@@ hdl/base64_stream_encoder_core.sv @@
// base64_stream_encoder_core: top level of the streaming base64 encoder
// depends on b64e_pkg, b64e_in_if, b64e_out_if, b64e_front, b64e_queue, b64e_back
//
// Encodes a byte stream to base64 with the standard alphabet and '=' padding.
// One byte is taken per cycle on byte_ch while the group queue has room; a third
// byte, or any byte marked last, completes a group. With the back end idle, that
// group is written into the group queue, then loaded into the back end, which
// then offers its first character on char_ch. Each group leaves as four
// characters, one per cycle while char_ch is ready, so the sustained rate is set
// by the character output of the back end, not by the byte intake. A message
// ending in a one- or two-byte group still yields four characters. The
// QUEUE_DEPTH groups of buffering let the input keep flowing while the output is
// stalled, until the queue is full; end_of_text marks the fourth character of
// the final group.
module base64_stream_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  b64e_in_if.sink     byte_ch,
  b64e_out_if.source  char_ch
);
  import b64e_pkg::*;

  group_t front_grp;
  logic   front_push;
  logic   queue_full;
  group_t queue_head;
  logic   queue_not_empty;
  logic   back_pop;

  // byte intake and grouping
  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .grp      (front_grp),
    .grp_push (front_push),
    .grp_full (queue_full)
  );

  // group queue
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_grp    (front_grp),
    .push      (front_push),
    .full      (queue_full),
    .rd_grp    (queue_head),
    .not_empty (queue_not_empty),
    .pop       (back_pop)
  );

  // character output
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (queue_head),
    .head_valid (queue_not_empty),
    .pop        (back_pop),
    .char_ch    (char_ch)
  );

endmodule

@@ hdl/b64e_front.sv @@
// b64e_front: takes bytes, holds up to two, and forms complete groups
// depends on b64e_pkg and b64e_in_if
module b64e_front (
  input  logic            clk,
  input  logic            rst,
  b64e_in_if.sink         byte_ch,
  output b64e_pkg::group_t grp,
  output logic            grp_push,
  input  logic            grp_full
);
  import b64e_pkg::*;

  logic [7:0] held_bytes [2];
  logic [1:0] held_count;
  logic [1:0] cnt;
  logic       accept;
  logic       completes;

  // a held count of three is treated like two
  assign cnt = (held_count == GROUP_THREE) ? HELD_TWO : held_count;

  // transaction accepted whenever the queue has room
  assign byte_ch.ready = !grp_full;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign completes     = byte_ch.last_byte || (cnt == HELD_TWO);
  assign grp_push      = accept && completes;

  // assemble the group from held bytes and the incoming one
  always_comb begin
    grp.b0     = (cnt != HELD_NONE) ? held_bytes[0] : byte_ch.data_byte;
    grp.b1     = (cnt == HELD_TWO) ? held_bytes[1] :
                 (cnt == HELD_ONE) ? byte_ch.data_byte : 8'd0;
    grp.b2     = (cnt == HELD_TWO) ? byte_ch.data_byte : 8'd0;
    grp.nbytes = cnt + 2'd1;
    grp.last   = byte_ch.last_byte;
  end

  // pending byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
    end else if (accept) begin
      held_count <= completes ? HELD_NONE : cnt + 2'd1;
    end
  end

  // pending byte store
  always_ff @(posedge clk) begin
    if (accept && !completes) begin
      held_bytes[cnt[0]] <= byte_ch.data_byte;
    end
  end

  a_count_never_three: assert property (@(posedge clk) disable iff (rst)
    held_count != GROUP_THREE)
    else $error("held count reached three");

  a_pending_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && !completes) |=> held_count == $past(cnt) + 2'd1)
    else $error("pending byte did not advance held count");

  a_group_clears: assert property (@(posedge clk) disable iff (rst)
    grp_push |=> held_count == HELD_NONE)
    else $error("held count not cleared after group");

endmodule

@@ hdl/b64e_queue.sv @@
// b64e_queue: short register queue of groups between front and back
// depends on b64e_pkg
module b64e_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  b64e_pkg::group_t wr_grp,
  input  logic             push,
  output logic             full,
  output b64e_pkg::group_t rd_grp,
  output logic             not_empty,
  input  logic             pop
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t            entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_grp    = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // group storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_grp;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("group pushed into a full queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow the queue");

endmodule

@@ hdl/b64e_back.sv @@
// b64e_back: takes groups from the queue and sends four characters each
// depends on b64e_pkg and b64e_out_if
module b64e_back (
  input  logic             clk,
  input  logic             rst,
  input  b64e_pkg::group_t head,
  input  logic             head_valid,
  output logic             pop,
  b64e_out_if.source       char_ch
);
  import b64e_pkg::*;

  group_t    cur;
  char_idx_t idx;
  logic      busy;
  logic      out_fire;
  logic      load;
  logic [5:0] sextet;
  logic      pad;

  assign out_fire = char_ch.valid && char_ch.ready;
  // next group enters as soon as the fourth character leaves
  assign load     = head_valid && (!busy || (out_fire && idx == IDX_FOURTH));
  assign pop      = load;

  // current group and character position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_FIRST;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= IDX_FIRST;
    end else if (out_fire) begin
      if (idx == IDX_FOURTH) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

  // six-bit slice for the current position
  always_comb begin
    case (idx)
      IDX_FIRST:  sextet = cur.b0[7:2];
      IDX_SECOND: sextet = {cur.b0[1:0], cur.b1[7:4]};
      IDX_THIRD:  sextet = {cur.b1[3:0], cur.b2[7:6]};
      default:    sextet = cur.b2[5:0];
    endcase
  end

  // padding for short final groups
  assign pad = ((idx == IDX_THIRD) && (cur.nbytes < GROUP_TWO)) ||
               ((idx == IDX_FOURTH) && (cur.nbytes < GROUP_THREE));

  assign char_ch.valid       = busy;
  assign char_ch.out_char    = pad ? PAD_CHAR : sextet_char(sextet);
  assign char_ch.end_of_text = cur.last && (idx == IDX_FOURTH);

  a_idle_after_group: assert property (@(posedge clk) disable iff (rst)
    (out_fire && idx == IDX_FOURTH && !head_valid) |=> !busy)
    else $error("back stayed busy with no group left");

  a_idx_advances: assert property (@(posedge clk) disable iff (rst)
    (out_fire && idx != IDX_FOURTH) |=> (busy && idx == $past(idx) + 2'd1))
    else $error("character position did not advance");

  a_no_early_pad: assert property (@(posedge clk) disable iff (rst)
    (busy && (idx == IDX_FIRST || idx == IDX_SECOND)) |-> char_ch.out_char != PAD_CHAR)
    else $error("padding on first or second character");

endmodule
